FILE: rtl/vcf_genotype_stream_parser_macros.svh
// Assertion macros for the VCF genotype stream parser.
// Depends on nothing; users must have clk and rst in scope.
`ifndef VCF_GENOTYPE_STREAM_PARSER_MACROS_SVH
`define VCF_GENOTYPE_STREAM_PARSER_MACROS_SVH
`ifndef SYNTH
`define VGSP_ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
`define VGSP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define VGSP_ASSERT_IMPLIES(label, pre, post, msg)
`define VGSP_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: rtl/vgsp_pkg.sv
// Shared types, constants and character decoding for the VCF genotype parser.
// No dependencies.
package vgsp_pkg;

  localparam int DEF_MAX_PLOIDY  = 8;
  localparam int DEF_MAX_ALLELES = 10;
  localparam int DEF_MAX_SAMPLES = 1024;

  // Result kinds.
  localparam logic [1:0] KIND_POS  = 2'd0;
  localparam logic [1:0] KIND_GENO = 2'd1;
  localparam logic [1:0] KIND_EOR  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_PLOIDY       = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  localparam logic [3:0]  PLOIDY_RESET       = 4'd2;
  localparam logic [10:0] SAMPLE_COUNT_RESET = 11'd1;

  // Text bytes of interest.
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Column numbers within a record; sample columns saturate at FIELD_SAMPLE.
  localparam logic [3:0] FIELD_POS    = 4'd1;
  localparam logic [3:0] FIELD_REF    = 4'd3;
  localparam logic [3:0] FIELD_ALT    = 4'd4;
  localparam logic [3:0] FIELD_SAMPLE = 4'd9;

  localparam logic [2:0]  CODE_OTHER = 3'd5;
  localparam logic [30:0] POS_MAX    = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] site_index;
    logic [12:0] column;
    logic [30:0] value;
  } result_t;

  function automatic logic [2:0] nuc_code(input logic [7:0] c);
    logic [2:0] code;
    case (c) inside
      8'h54, 8'h74, 8'h55, 8'h75: code = 3'd1;
      8'h43, 8'h63:               code = 3'd2;
      8'h47, 8'h67:               code = 3'd3;
      8'h41, 8'h61:               code = 3'd4;
      8'h2D:                      code = 3'd6;
      default:                    code = CODE_OTHER;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/vcf_genotype_stream_parser.sv
// Channel   Direction  Signals                                      Transaction
// input     in         in_valid, in_ready, data_byte                one text byte
// result    out        out_valid, out_ready, kind, site_index,      one result item
//                      column, value
// config    in         cfg_write, cfg_index, cfg_data               one register write
//
// One byte is taken every cycle while in_ready is high; the parser updates its field
// state in the same cycle and a result, if any, is visible on the output in the cycle
// after its byte when the output register is free or being emptied. Results sit in a
// two-entry buffer, so in_ready drops only while both entries are full; it rises again
// the cycle after the consumer takes a result. Reset needs no clearing pass; the
// allele table is filled by each record before any lookup can reach it.
// Depends on vgsp_pkg, vgsp_allele_table, vgsp_out_buf and the macros header.
`include "vcf_genotype_stream_parser_macros.svh"

module vcf_genotype_stream_parser #(
  parameter int MAX_PLOIDY  = vgsp_pkg::DEF_MAX_PLOIDY,
  parameter int MAX_ALLELES = vgsp_pkg::DEF_MAX_ALLELES,
  parameter int MAX_SAMPLES = vgsp_pkg::DEF_MAX_SAMPLES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [23:0] site_index,
  output logic [12:0] column,
  output logic [30:0] value,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int IW = $clog2(MAX_ALLELES);
  localparam int CW = $clog2(MAX_ALLELES + 1);

  // Configuration.
  logic [3:0]  ploidy;
  logic [10:0] sample_count;

  // Parser state.
  logic          at_line_start, at_line_start_next;
  logic          header_line, header_line_next;
  logic [3:0]    field_number, field_number_next;
  logic [4:0]    field_offset, field_offset_next;
  logic [30:0]   position_accum, position_accum_next;
  logic          pos_stopped, pos_stopped_next;
  logic [CW-1:0] allele_count, allele_count_next;
  logic [1:0]    allele_length, allele_length_next;
  logic [2:0]    allele_first_code, allele_first_code_next;
  logic [10:0]   sample_number, sample_number_next;
  logic [23:0]   site_counter, site_counter_next;

  // Line-start view of the state: a new data line starts from cleared fields.
  logic          hdr_c;
  logic [3:0]    fn_c;
  logic [4:0]    fo_c;
  logic [30:0]   pos_c;
  logic          stop_c;
  logic [CW-1:0] cnt_c;
  logic [1:0]    len_c;
  logic [2:0]    first_c;
  logic [10:0]   sn_c;

  logic              accept;
  logic              buf_full;
  logic              res_valid;
  vgsp_pkg::result_t res;
  vgsp_pkg::result_t out_data;

  logic          is_digit;
  logic [3:0]    digit;
  logic [34:0]   pos_times_ten;
  logic [2:0]    finished_code;
  logic          store_ok;
  logic          tbl_we;
  logic [IW-1:0] tbl_wi;
  logic [2:0]    geno_code;
  logic [3:0]    ploidy_eff;
  logic [3:0]    slot;
  logic          slot_ok;
  logic          sample_ok;
  logic [14:0]   column_base;

  assign accept   = in_valid && in_ready;
  assign in_ready = !buf_full;

  assign hdr_c   = at_line_start ? 1'b0 : header_line;
  assign fn_c    = at_line_start ? '0 : field_number;
  assign fo_c    = at_line_start ? '0 : field_offset;
  assign pos_c   = at_line_start ? '0 : position_accum;
  assign stop_c  = at_line_start ? 1'b0 : pos_stopped;
  assign cnt_c   = at_line_start ? '0 : allele_count;
  assign len_c   = at_line_start ? '0 : allele_length;
  assign first_c = at_line_start ? vgsp_pkg::CODE_OTHER : allele_first_code;
  assign sn_c    = at_line_start ? '0 : sample_number;

  assign is_digit      = (data_byte >= vgsp_pkg::CH_ZERO) && (data_byte <= vgsp_pkg::CH_NINE);
  assign digit         = 4'(data_byte - vgsp_pkg::CH_ZERO);
  assign pos_times_ten = (35'(pos_c) << 3) + (35'(pos_c) << 1) + 35'(digit);
  assign finished_code = (len_c == 2'd1) ? first_c : vgsp_pkg::CODE_OTHER;
  assign store_ok      = 32'(cnt_c) < MAX_ALLELES;

  assign ploidy_eff = (ploidy == 4'd0) ? 4'd1 :
                      (32'(ploidy) > MAX_PLOIDY) ? 4'(MAX_PLOIDY) : ploidy;
  assign slot       = 4'(fo_c[4:1]);
  assign slot_ok    = !fo_c[0] && (slot < ploidy_eff);
  assign sample_ok  = (sn_c < sample_count) && (32'(sn_c) < MAX_SAMPLES);
  assign column_base = 15'(ploidy_eff) * 15'(sn_c);

  vgsp_allele_table #(
    .DEPTH(MAX_ALLELES)
  ) u_alleles (
    .clk      (clk),
    .wr_en    (accept && tbl_we),
    .wr_index (tbl_wi),
    .wr_code  (finished_code),
    .rd_digit (is_digit ? digit : 4'hF),
    .rd_count (cnt_c),
    .rd_code  (geno_code)
  );

  always_comb begin
    at_line_start_next     = 1'b0;
    header_line_next       = hdr_c;
    field_number_next      = fn_c;
    field_offset_next      = fo_c;
    position_accum_next    = pos_c;
    pos_stopped_next       = stop_c;
    allele_count_next      = cnt_c;
    allele_length_next     = len_c;
    allele_first_code_next = first_c;
    sample_number_next     = sn_c;
    site_counter_next      = site_counter;
    tbl_we                 = 1'b0;
    tbl_wi                 = IW'(cnt_c);
    res_valid              = 1'b0;
    res.kind               = vgsp_pkg::KIND_POS;
    res.site_index         = site_counter;
    res.column             = '0;
    res.value              = '0;

    if (at_line_start && data_byte == vgsp_pkg::CH_HASH) begin
      header_line_next = 1'b1;
    end else if (hdr_c) begin
      at_line_start_next = (data_byte == vgsp_pkg::CH_NL);
    end else if (data_byte == vgsp_pkg::CH_NL) begin
      res_valid          = 1'b1;
      res.kind           = vgsp_pkg::KIND_EOR;
      site_counter_next  = site_counter + 24'd1;
      at_line_start_next = 1'b1;
    end else if (data_byte == vgsp_pkg::CH_TAB) begin
      if (fn_c == vgsp_pkg::FIELD_POS) begin
        res_valid = 1'b1;
        res.kind  = vgsp_pkg::KIND_POS;
        res.value = pos_c;
      end else if (fn_c == vgsp_pkg::FIELD_REF) begin
        tbl_we            = 1'b1;
        tbl_wi            = '0;
        allele_count_next = CW'(1);
      end else if (fn_c == vgsp_pkg::FIELD_ALT && len_c != 2'd0 && store_ok) begin
        tbl_we            = 1'b1;
        allele_count_next = cnt_c + CW'(1);
      end
      if (fn_c < vgsp_pkg::FIELD_SAMPLE) begin
        field_number_next = fn_c + 4'd1;
      end else if (sn_c != 11'h7FF) begin
        sample_number_next = sn_c + 11'd1;
      end
      field_offset_next      = '0;
      allele_length_next     = '0;
      allele_first_code_next = vgsp_pkg::CODE_OTHER;
    end else begin
      if (fn_c == vgsp_pkg::FIELD_POS) begin
        // Digits accumulate until the first non-digit; the rest of POS is ignored.
        if (!stop_c) begin
          if (is_digit) begin
            position_accum_next = (pos_times_ten > 35'(vgsp_pkg::POS_MAX)) ?
                                  vgsp_pkg::POS_MAX : pos_times_ten[30:0];
          end else begin
            pos_stopped_next = 1'b1;
          end
        end
      end else if (fn_c == vgsp_pkg::FIELD_ALT && data_byte == vgsp_pkg::CH_COMMA) begin
        if (len_c != 2'd0 && store_ok) begin
          tbl_we            = 1'b1;
          allele_count_next = cnt_c + CW'(1);
        end
        allele_length_next     = '0;
        allele_first_code_next = vgsp_pkg::CODE_OTHER;
      end else if (fn_c == vgsp_pkg::FIELD_REF || fn_c == vgsp_pkg::FIELD_ALT) begin
        if (len_c == 2'd0) begin
          allele_first_code_next = vgsp_pkg::nuc_code(data_byte);
        end
        if (len_c != 2'd2) begin
          allele_length_next = len_c + 2'd1;
        end
      end else if (fn_c >= vgsp_pkg::FIELD_SAMPLE) begin
        if (slot_ok && sample_ok) begin
          res_valid  = 1'b1;
          res.kind   = vgsp_pkg::KIND_GENO;
          res.column = column_base[12:0] + 13'(slot);
          res.value  = 31'(geno_code);
        end
      end
      if (fo_c != 5'd31) begin
        field_offset_next = fo_c + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ploidy       <= vgsp_pkg::PLOIDY_RESET;
      sample_count <= vgsp_pkg::SAMPLE_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vgsp_pkg::REG_PLOIDY:       ploidy       <= cfg_data[3:0];
        vgsp_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start     <= 1'b1;
      header_line       <= 1'b0;
      field_number      <= '0;
      field_offset      <= '0;
      position_accum    <= '0;
      pos_stopped       <= 1'b0;
      allele_count      <= '0;
      allele_length     <= '0;
      allele_first_code <= vgsp_pkg::CODE_OTHER;
      sample_number     <= '0;
      site_counter      <= '0;
    end else if (accept) begin
      at_line_start     <= at_line_start_next;
      header_line       <= header_line_next;
      field_number      <= field_number_next;
      field_offset      <= field_offset_next;
      position_accum    <= position_accum_next;
      pos_stopped       <= pos_stopped_next;
      allele_count      <= allele_count_next;
      allele_length     <= allele_length_next;
      allele_first_code <= allele_first_code_next;
      sample_number     <= sample_number_next;
      site_counter      <= site_counter_next;
    end
  end

  vgsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign kind       = out_data.kind;
  assign site_index = out_data.site_index;
  assign column     = out_data.column;
  assign value      = out_data.value;

  `VGSP_ASSERT_IMPLIES(a_stall_needs_result, !in_ready, out_valid, "input stalled with no result pending")
  `VGSP_ASSERT_IMPLIES(a_geno_code_range, out_valid && kind == vgsp_pkg::KIND_GENO, value >= 31'd1 && value <= 31'd6, "genotype code out of range")
  `VGSP_ASSERT_IMPLIES(a_column_only_geno, out_valid && kind != vgsp_pkg::KIND_GENO, column == 13'd0, "column set on a non-genotype result")
  `VGSP_ASSERT_NEXT(a_result_shows, accept && res_valid && !out_valid, out_valid, "result lost on its way to the output")

endmodule

FILE: rtl/vgsp_allele_table.sv
// Per-record allele code table with bounds-checked genotype digit lookup.
// Depends on vgsp_pkg.
module vgsp_allele_table #(
  parameter int DEPTH = vgsp_pkg::DEF_MAX_ALLELES
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_index,
  input  logic [2:0]                 wr_code,
  input  logic [3:0]                 rd_digit,
  input  logic [$clog2(DEPTH+1)-1:0] rd_count,
  output logic [2:0]                 rd_code
);

  localparam int IW = $clog2(DEPTH);

  logic [2:0] codes [DEPTH];
  logic       digit_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      codes[wr_index] <= wr_code;
    end
  end

  // A digit naming an allele that this record never defined reads as "other".
  assign digit_ok = (32'(rd_digit) < 32'(rd_count)) && (32'(rd_digit) < DEPTH);
  assign rd_code  = digit_ok ? codes[rd_digit[IW-1:0]] : vgsp_pkg::CODE_OTHER;

endmodule

FILE: rtl/vgsp_out_buf.sv
// Two-entry result buffer: an output register plus a skid register.
// Depends on vgsp_pkg.
module vgsp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vgsp_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output vgsp_pkg::result_t out_data
);

  logic              main_valid;
  logic              skid_valid;
  vgsp_pkg::result_t main_data;
  vgsp_pkg::result_t skid_data;
  logic              pop;

  assign pop       = main_valid && out_ready;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // The producer is held off while the skid entry is occupied.
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule
